// ===== rtl/v3n_pkg.sv =====
`default_nettype none
package v3n_pkg;
    localparam int WordBits = 32;
    localparam int FracBits = 16;
    localparam int UnitBits = FracBits + 2;
    localparam int SumBits  = 2 * WordBits + 2;
    // root digits: one per cell
    localparam int SqrtSteps = WordBits + 1;
    localparam int RootBits  = WordBits + 1;
    // remainder wide enough for 2*root+1
    localparam int RemBits   = RootBits + 2;
    localparam int DivSteps  = FracBits + 1;

    typedef struct packed {
        logic [SumBits-1:0]  rad;
        logic [RootBits-1:0] root;
        logic [RemBits-1:0]  rem;
        logic [WordBits-1:0] ax;
        logic [WordBits-1:0] ay;
        logic [WordBits-1:0] az;
        logic [2:0]          neg;
    } sq_item_t;

    typedef struct packed {
        logic [WordBits-1:0] mag;
        logic [WordBits:0]   rx;
        logic [WordBits:0]   ry;
        logic [WordBits:0]   rz;
        logic [DivSteps-1:0] qx;
        logic [DivSteps-1:0] qy;
        logic [DivSteps-1:0] qz;
        logic [2:0]          neg;
    } dv_item_t;
endpackage
`default_nettype wire

// ===== rtl/v3n_sqrt_cell.sv =====
`default_nettype none
// One digit of the non-restoring-free (restoring) bitwise square root.
module v3n_sqrt_cell (
    input  wire                aclk,
    input  wire                aresetn,
    input  wire                en,
    input  wire                vld_in,
    input  v3n_pkg::sq_item_t  d_in,
    output logic               vld_out,
    output v3n_pkg::sq_item_t  d_out
);
    logic [v3n_pkg::RemBits-1:0] rem_sh;
    logic [v3n_pkg::RemBits-1:0] trial;
    v3n_pkg::sq_item_t           d_next;

    // bring down two radicand bits, try root*4+1
    always_comb begin
        d_next = d_in;
        rem_sh = {d_in.rem[v3n_pkg::RemBits-3:0],
                  d_in.rad[v3n_pkg::SumBits-1 -: 2]};
        trial  = {d_in.root[v3n_pkg::RootBits-1:0], 2'b01};
        d_next.rad = {d_in.rad[v3n_pkg::SumBits-3:0], 2'b00};
        if (rem_sh >= trial) begin
            d_next.rem  = rem_sh - trial;
            d_next.root = {d_in.root[v3n_pkg::RootBits-2:0], 1'b1};
        end else begin
            d_next.rem  = rem_sh;
            d_next.root = {d_in.root[v3n_pkg::RootBits-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_out <= 1'b0;
        end else if (en) begin
            vld_out <= vld_in;
        end
        if (en) begin
            d_out <= d_next;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/v3n_div_cell.sv =====
`default_nettype none
// One quotient bit for all three components.
module v3n_div_cell (
    input  wire                aclk,
    input  wire                aresetn,
    input  wire                en,
    input  wire                first,
    input  wire                vld_in,
    input  v3n_pkg::dv_item_t  d_in,
    output logic               vld_out,
    output v3n_pkg::dv_item_t  d_out
);
    localparam int W = v3n_pkg::WordBits;
    v3n_pkg::dv_item_t d_next;
    logic [W:0] sx, sy, sz, m;

    always_comb begin
        d_next = d_in;
        m  = {1'b0, d_in.mag};
        // first cell compares without shifting
        sx = first ? d_in.rx : {d_in.rx[W-1:0], 1'b0};
        sy = first ? d_in.ry : {d_in.ry[W-1:0], 1'b0};
        sz = first ? d_in.rz : {d_in.rz[W-1:0], 1'b0};
        d_next.rx = (sx >= m) ? sx - m : sx;
        d_next.ry = (sy >= m) ? sy - m : sy;
        d_next.rz = (sz >= m) ? sz - m : sz;
        d_next.qx = {d_in.qx[v3n_pkg::DivSteps-2:0], sx >= m};
        d_next.qy = {d_in.qy[v3n_pkg::DivSteps-2:0], sy >= m};
        d_next.qz = {d_in.qz[v3n_pkg::DivSteps-2:0], sz >= m};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_out <= 1'b0;
        end else if (en) begin
            vld_out <= vld_in;
        end
        if (en) begin
            d_out <= d_next;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/vector3_normalize_top.sv =====
`default_nettype none
// channel | valid/ready     | payload
// s_      | s_valid/s_ready | s_x_in, s_y_in, s_z_in (signed Q16.16)
// m_      | m_valid/m_ready | m_unit_x/y/z, m_magnitude, m_zero_length
// One item per cycle sustained while the output is not stalled; input stages,
// 33 root cells, 17 divide cells, output register. The 50 cells plus input stages
// form one shift chain. The output register parts the sides: the chain advances
// while the output slot is empty or is being taken. Reset clears all valid bits.
module vector3_normalize_top (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_valid,
    output logic                s_ready,
    input  wire signed [31:0]   s_x_in,
    input  wire signed [31:0]   s_y_in,
    input  wire signed [31:0]   s_z_in,
    output logic                m_valid,
    input  wire                 m_ready,
    output logic signed [17:0]  m_unit_x,
    output logic signed [17:0]  m_unit_y,
    output logic signed [17:0]  m_unit_z,
    output logic [31:0]         m_magnitude,
    output logic                m_zero_length
);
    localparam int W  = v3n_pkg::WordBits;
    localparam int NS = v3n_pkg::SqrtSteps;
    localparam int ND = v3n_pkg::DivSteps;
    localparam int UB = v3n_pkg::UnitBits;

    logic en;
    logic chain_vld;
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    // stages A and B: absolute values, then squares
    logic               a_vld_reg;
    logic [W-1:0]       ax_reg, ay_reg, az_reg;
    logic [2:0]         neg_reg;
    logic [2*W-1:0]     px_reg, py_reg, pz_reg;
    logic               b_vld_reg;
    logic [W-1:0]       bx_reg, by_reg, bz_reg;
    logic [2:0]         bneg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
        end else if (en) begin
            a_vld_reg <= s_valid;
            b_vld_reg <= a_vld_reg;
        end
        if (en) begin
            ax_reg  <= s_x_in[W-1] ? W'(-s_x_in) : s_x_in;
            ay_reg  <= s_y_in[W-1] ? W'(-s_y_in) : s_y_in;
            az_reg  <= s_z_in[W-1] ? W'(-s_z_in) : s_z_in;
            neg_reg <= {s_z_in[W-1], s_y_in[W-1], s_x_in[W-1]};
            px_reg  <= ax_reg * ax_reg;
            py_reg  <= ay_reg * ay_reg;
            pz_reg  <= az_reg * az_reg;
            bx_reg  <= ax_reg;
            by_reg  <= ay_reg;
            bz_reg  <= az_reg;
            bneg_reg <= neg_reg;
        end
    end

    // root chain
    v3n_pkg::sq_item_t sq_d [NS+1];
    logic              sq_v [NS+1];
    always_comb begin
        sq_d[0].rad  = {2'b00, px_reg} + {2'b00, py_reg} + {2'b00, pz_reg};
        sq_d[0].root = '0;
        sq_d[0].rem  = '0;
        sq_d[0].ax   = bx_reg;
        sq_d[0].ay   = by_reg;
        sq_d[0].az   = bz_reg;
        sq_d[0].neg  = bneg_reg;
        sq_v[0]      = b_vld_reg;
    end
    for (genvar i = 0; i < NS; i++) begin : g_sq
        v3n_sqrt_cell u_cell (
            .aclk(aclk), .aresetn(aresetn), .en(en),
            .vld_in(sq_v[i]), .d_in(sq_d[i]),
            .vld_out(sq_v[i+1]), .d_out(sq_d[i+1])
        );
    end

    // divide chain; components clipped to magnitude
    v3n_pkg::dv_item_t dv_d [ND+1];
    logic              dv_v [ND+1];
    logic [W-1:0]      mag0;
    always_comb begin
        mag0 = sq_d[NS].root[W-1:0];
        dv_d[0].mag = mag0;
        dv_d[0].rx  = {1'b0, (sq_d[NS].ax > mag0) ? mag0 : sq_d[NS].ax};
        dv_d[0].ry  = {1'b0, (sq_d[NS].ay > mag0) ? mag0 : sq_d[NS].ay};
        dv_d[0].rz  = {1'b0, (sq_d[NS].az > mag0) ? mag0 : sq_d[NS].az};
        dv_d[0].qx  = '0;
        dv_d[0].qy  = '0;
        dv_d[0].qz  = '0;
        dv_d[0].neg = sq_d[NS].neg;
        dv_v[0]     = sq_v[NS];
    end
    for (genvar j = 0; j < ND; j++) begin : g_dv
        v3n_div_cell u_cell (
            .aclk(aclk), .aresetn(aresetn), .en(en), .first(j == 0),
            .vld_in(dv_v[j]), .d_in(dv_d[j]),
            .vld_out(dv_v[j+1]), .d_out(dv_d[j+1])
        );
    end
    assign chain_vld = dv_v[ND];

    // output register; zero magnitude forces zero units
    logic           zl;
    logic [UB-1:0]  ux, uy, uz;
    always_comb begin
        zl = dv_d[ND].mag == '0;
        ux = zl ? '0 : {1'b0, dv_d[ND].qx};
        uy = zl ? '0 : {1'b0, dv_d[ND].qy};
        uz = zl ? '0 : {1'b0, dv_d[ND].qz};
    end
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid <= 1'b0;
        end else if (en) begin
            m_valid <= chain_vld;
        end
        if (en) begin
            m_unit_x      <= dv_d[ND].neg[0] ? UB'(-ux) : ux;
            m_unit_y      <= dv_d[ND].neg[1] ? UB'(-uy) : uy;
            m_unit_z      <= dv_d[ND].neg[2] ? UB'(-uz) : uz;
            m_magnitude   <= dv_d[ND].mag;
            m_zero_length <= zl;
        end
    end

`ifndef SYNTHESIS
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !s_ready) else $error("ready while stalled");
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_zero_length == (m_magnitude == '0)))
        else $error("zero flag mismatch");
    a_unit: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_zero_length) |-> (m_unit_x == '0 && m_unit_y == '0
        && m_unit_z == '0)) else $error("zero vector unit nonzero");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(dv_v[ND])) else $error("chain moved while stalled");
`endif
endmodule
`default_nettype wire
